/* rtl/ipv4_address_port_parser_assert.svh */
// assertion macros shared by the address parser modules
`ifndef IPV4_ADDRESS_PORT_PARSER_ASSERT_SVH
`define IPV4_ADDRESS_PORT_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IPAP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define IPAP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ipap_pkg.sv */
// shared types, constants and helpers of the address and port parser
package ipap_pkg;

    localparam int MAX_TEXT_LENGTH_DEF = 64;
    localparam int QUEUE_DEPTH         = 4;
    localparam int CFG_INDEX_W         = 8;
    localparam int CFG_DATA_W          = 32;
    localparam int PORT_W              = 16;
    localparam int ADDR_W              = 32;
    localparam int OUT_DATA_W          = ADDR_W + PORT_W;
    localparam int NAME_LEN            = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_PORT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOPBACK     = CFG_INDEX_W'(1);

    localparam logic [PORT_W-1:0] DEFAULT_PORT_RST = 16'd7777;
    localparam logic [ADDR_W-1:0] LOOPBACK_RST     = 32'h7F00_0001;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_HOST,
        PH_PORT
    } phase_t;

    // one classified character as it travels from front to back
    typedef struct packed {
        logic       last;
        logic       is_space;
        logic       is_digit;
        logic       is_dot;
        logic       is_colon;
        logic [3:0] digit;
        logic [7:0] lower;
    } cls_t;

    // characters of the loopback host name
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h6C;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h63;
            4'd3:    c = 8'h61;
            4'd4:    c = 8'h6C;
            4'd5:    c = 8'h68;
            4'd6:    c = 8'h6F;
            4'd7:    c = 8'h73;
            4'd8:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/ipv4_address_port_parser.sv */
// Address text parser: takes one character per item on the slave stream
// (tlast marks the final character), trims surrounding whitespace and
// recognizes either a case-insensitive "localhost" (giving the loopback
// address register) or a dotted quad of 1 to 3 digit octets no greater than
// 255, optionally followed by a colon and a port of 1 to 5 digits in
// 1..65535; with no colon the default port register is used. Exactly one
// result item leaves per text, after its last character: tuser is the valid
// flag and tdata holds address and port, both zero when invalid. A new
// character is taken every cycle while the four-entry queue has room; the
// front classifier pushes into the queue and the back parser retires one
// character per cycle unless a last character waits on a held result, so
// sustained rate is one item per clock. With the queue empty, the last
// character passes the queue register and then the result register before
// m_tvalid rises; characters waiting in the queue ahead of it go first.
// A stalled result only holds back the next last character; the queue then
// fills and s_tready drops until the result is taken.
// Configuration writes (index 0 default port, 1 loopback address) are taken
// every cycle and must be made while no text is in flight.
module ipv4_address_port_parser #(
    parameter int MAX_TEXT_LENGTH = ipap_pkg::MAX_TEXT_LENGTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // character stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,    // text_char
    input  logic                                s_tlast,    // last_char
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ipap_pkg::OUT_DATA_W-1:0]     m_tdata,    // ipv4_address, port_number
    output logic                                m_tuser,    // valid_res
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ipap_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ipap_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [ipap_pkg::PORT_W-1:0] default_port_reg, default_port_next;
    logic [ipap_pkg::ADDR_W-1:0] loopback_reg, loopback_next;

    logic           queue_full;
    logic           queue_avail;
    logic           push;
    logic           pop;
    ipap_pkg::cls_t push_item;
    ipap_pkg::cls_t pop_item;

    // register file, always ready
    assign cfg_ready = 1'b1;

    always_comb begin
        default_port_next = default_port_reg;
        loopback_next     = loopback_reg;
        if (cfg_valid) begin
            case (cfg_index)
                ipap_pkg::CFG_DEFAULT_PORT: default_port_next = cfg_data[ipap_pkg::PORT_W-1:0];
                ipap_pkg::CFG_LOOPBACK:     loopback_next     = cfg_data[ipap_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_port_reg <= ipap_pkg::DEFAULT_PORT_RST;
            loopback_reg     <= ipap_pkg::LOOPBACK_RST;
        end else begin
            default_port_reg <= default_port_next;
            loopback_reg     <= loopback_next;
        end
    end

    // classify incoming characters
    ipap_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // decouples intake from the parser and the result stall
    ipap_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .not_empty (queue_avail),
        .pop       (pop),
        .pop_item  (pop_item)
    );

    // parse state machine and result register
    ipap_back #(
        .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .default_port     (default_port_reg),
        .loopback_address (loopback_reg),
        .item_avail       (queue_avail),
        .item             (pop_item),
        .pop              (pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser)
    );

endmodule

/* rtl/ipap_queue.sv */
// small register queue between the classifier and the parser
`include "ipv4_address_port_parser_assert.svh"

module ipap_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ipap_pkg::cls_t push_item,
    output logic          full,
    output logic          not_empty,
    input  logic          pop,
    output ipap_pkg::cls_t pop_item
);

    localparam int DEPTH = ipap_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipap_pkg::cls_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? PTR_W'((wr_ptr_reg + 1'b1) % DEPTH) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'((rd_ptr_reg + 1'b1) % DEPTH) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `IPAP_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `IPAP_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, pop, count_reg != '0, "pop from empty queue")
    `IPAP_ASSERT_NXT(a_push_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + CNT_W'(1), "push lost")

endmodule

/* rtl/ipap_front.sv */
// input side: takes characters and classifies them for the parser
module ipap_front (
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic           s_tlast,
    input  logic           queue_full,
    output logic           push,
    output ipap_pkg::cls_t push_item
);

    logic [7:0] c;

    assign c        = s_tdata;
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        push_item.last     = s_tlast;
        push_item.is_space = (c == ipap_pkg::CH_SPACE)
                          || (c >= ipap_pkg::CH_TAB && c <= ipap_pkg::CH_CR);
        push_item.is_digit = (c >= ipap_pkg::CH_ZERO && c <= ipap_pkg::CH_NINE);
        push_item.is_dot   = (c == ipap_pkg::CH_DOT);
        push_item.is_colon = (c == ipap_pkg::CH_COLON);
        push_item.digit    = 4'(c - ipap_pkg::CH_ZERO);
        push_item.lower    = (c >= ipap_pkg::CH_UPA && c <= ipap_pkg::CH_UPZ)
                           ? c + ipap_pkg::CASE_OFS : c;
    end

endmodule

/* rtl/ipap_back.sv */
// parse engine: per-character state update and result register
`include "ipv4_address_port_parser_assert.svh"

module ipap_back #(
    parameter int MAX_TEXT_LENGTH = ipap_pkg::MAX_TEXT_LENGTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [ipap_pkg::PORT_W-1:0]       default_port,
    input  logic [ipap_pkg::ADDR_W-1:0]       loopback_address,
    input  logic                              item_avail,
    input  ipap_pkg::cls_t                    item,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ipap_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser
);

    localparam int LEN_W = $clog2(MAX_TEXT_LENGTH + 1);

    ipap_pkg::phase_t phase_reg, phase_next, phase_take, phase_eff;
    logic [LEN_W-1:0] len_reg, len_next, n_len;
    logic             pend_reg, pend_next, n_pend;
    logic [2:0]       oidx_reg, oidx_next, n_oidx;
    logic [1:0]       odig_reg, odig_next, n_odig;
    logic [9:0]       oval_reg, oval_next, n_oval;
    logic [31:0]      addr_reg, addr_next, n_addr;
    logic [2:0]       pdig_reg, pdig_next, n_pdig;
    logic [16:0]      pacc_reg, pacc_next, n_pacc;
    logic [3:0]       npos_reg, npos_next, n_npos;
    logic             name_reg, name_next, n_name;
    logic             num_reg, num_next, n_num;
    logic             fail_reg, fail_next, n_fail;

    logic             out_valid_reg, out_valid_next;
    logic [ipap_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic             out_ok_reg, out_ok_next;

    logic             slot_free, pop_last, ord_take;
    logic             quad_ok, res_ok, num_final;
    logic [16:0]      res_port;
    logic [31:0]      res_addr;

    assign slot_free = !out_valid_reg || m_tready;
    assign pop       = item_avail && (!item.last || slot_free);
    assign pop_last  = pop && item.last;
    assign ord_take  = pop && !fail_reg && !item.is_space && !pend_reg
                    && (len_reg < LEN_W'(MAX_TEXT_LENGTH));
    assign phase_eff = (phase_reg == ipap_pkg::PH_LEAD) ? ipap_pkg::PH_HOST : phase_reg;

    // phase sequencing
    always_comb begin
        phase_take = phase_reg;
        if (ord_take) begin
            if (phase_eff == ipap_pkg::PH_HOST && item.is_colon) begin
                phase_take = ipap_pkg::PH_PORT;
            end else begin
                phase_take = phase_eff;
            end
        end
        phase_next = pop_last ? ipap_pkg::PH_LEAD : phase_take;
    end

    // parse datapath and result
    always_comb begin
        n_len  = len_reg;
        n_pend = pend_reg;
        n_oidx = oidx_reg;
        n_odig = odig_reg;
        n_oval = oval_reg;
        n_addr = addr_reg;
        n_pdig = pdig_reg;
        n_pacc = pacc_reg;
        n_npos = npos_reg;
        n_name = name_reg;
        n_num  = num_reg;
        n_fail = fail_reg;
        quad_ok = 1'b0;

        if (pop && !fail_reg) begin
            if (item.is_space) begin
                if (phase_reg != ipap_pkg::PH_LEAD) begin
                    n_pend = 1'b1;
                end
            end else if (!ord_take) begin
                n_fail = 1'b1;
            end else begin
                n_len = len_reg + LEN_W'(1);
                if (phase_eff == ipap_pkg::PH_HOST) begin
                    if (item.is_colon) begin
                        // close the host at the colon
                        if (num_reg && oidx_reg == 3'd3 && odig_reg != 2'd0
                            && oval_reg <= 10'd255) begin
                            n_addr = {addr_reg[23:0], oval_reg[7:0]};
                            n_oidx = 3'd4;
                        end else begin
                            n_num = 1'b0;
                        end
                    end else begin
                        if (name_reg) begin
                            if (npos_reg < 4'(ipap_pkg::NAME_LEN)
                                && item.lower == ipap_pkg::name_char(npos_reg)) begin
                                n_npos = npos_reg + 4'd1;
                            end else begin
                                n_name = 1'b0;
                            end
                        end
                        if (num_reg) begin
                            if (item.is_dot) begin
                                if (odig_reg == 2'd0 || oval_reg > 10'd255
                                    || oidx_reg >= 3'd3) begin
                                    n_num = 1'b0;
                                end else begin
                                    n_addr = {addr_reg[23:0], oval_reg[7:0]};
                                    n_oidx = oidx_reg + 3'd1;
                                    n_odig = 2'd0;
                                    n_oval = 10'd0;
                                end
                            end else if (item.is_digit) begin
                                if (odig_reg == 2'd3) begin
                                    n_num = 1'b0;
                                end else begin
                                    n_oval = 10'(oval_reg * 10'd10 + 10'(item.digit));
                                    n_odig = odig_reg + 2'd1;
                                end
                            end else begin
                                n_num = 1'b0;
                            end
                        end
                    end
                end else begin
                    if (item.is_digit && pdig_reg < 3'd5) begin
                        n_pacc = 17'(pacc_reg * 17'd10 + 17'(item.digit));
                        n_pdig = pdig_reg + 3'd1;
                    end else begin
                        n_fail = 1'b1;
                    end
                end
            end
        end

        // end-of-text evaluation on the state after this character
        quad_ok = n_num && n_oidx == 3'd3 && n_odig != 2'd0 && n_oval <= 10'd255;
        if (phase_take == ipap_pkg::PH_HOST) begin
            res_port  = 17'(default_port);
            num_final = quad_ok;
            res_addr  = {n_addr[23:0], n_oval[7:0]};
        end else begin
            res_port  = (n_pdig != 3'd0) ? n_pacc : 17'd0;
            num_final = n_num && n_oidx == 3'd4;
            res_addr  = n_addr;
        end
        res_ok = !n_fail && n_len != '0 && phase_take != ipap_pkg::PH_LEAD
              && res_port != 17'd0 && res_port <= 17'd65535;
        if (n_name && n_npos == 4'(ipap_pkg::NAME_LEN)) begin
            res_addr = loopback_address;
        end else if (!num_final) begin
            res_ok = 1'b0;
        end

        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_ok_next    = out_ok_reg;
        if (pop_last) begin
            out_valid_next = 1'b1;
            out_ok_next    = res_ok;
            out_data_next  = res_ok ? {res_port[15:0], res_addr} : '0;
        end

        if (pop_last) begin
            len_next  = '0;
            pend_next = 1'b0;
            oidx_next = 3'd0;
            odig_next = 2'd0;
            oval_next = 10'd0;
            addr_next = 32'd0;
            pdig_next = 3'd0;
            pacc_next = 17'd0;
            npos_next = 4'd0;
            name_next = 1'b1;
            num_next  = 1'b1;
            fail_next = 1'b0;
        end else begin
            len_next  = n_len;
            pend_next = n_pend;
            oidx_next = n_oidx;
            odig_next = n_odig;
            oval_next = n_oval;
            addr_next = n_addr;
            pdig_next = n_pdig;
            pacc_next = n_pacc;
            npos_next = n_npos;
            name_next = n_name;
            num_next  = n_num;
            fail_next = n_fail;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ipap_pkg::PH_LEAD;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            oidx_reg      <= 3'd0;
            odig_reg      <= 2'd0;
            oval_reg      <= 10'd0;
            addr_reg      <= 32'd0;
            pdig_reg      <= 3'd0;
            pacc_reg      <= 17'd0;
            npos_reg      <= 4'd0;
            name_reg      <= 1'b1;
            num_reg       <= 1'b1;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            oidx_reg      <= oidx_next;
            odig_reg      <= odig_next;
            oval_reg      <= oval_next;
            addr_reg      <= addr_next;
            pdig_reg      <= pdig_next;
            pacc_reg      <= pacc_next;
            npos_reg      <= npos_next;
            name_reg      <= name_next;
            num_reg       <= num_next;
            fail_reg      <= fail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    `IPAP_ASSERT_NXT(a_last_gives_result, aclk, aresetn, pop_last, out_valid_reg, "end of text gave no result")
    `IPAP_ASSERT_IMP(a_invalid_zero, aclk, aresetn, out_valid_reg && !out_ok_reg, out_data_reg == '0, "invalid result carries data")
    `IPAP_ASSERT_NXT(a_fail_sticky, aclk, aresetn, fail_reg && !pop_last, fail_reg, "failure cleared inside text")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// self-checking testbench for the address and port text parser
module tb_top;

    localparam int    CYCLE_LIMIT  = 400000;
    localparam int    DRAIN_CYCLES = 12;     // queue stage plus result register, with margin
    localparam int    LONG_HOLD    = 300;    // receiver stall long enough to back up the input
    localparam string HOST_NAME    = "localhost";

    // one character of address text as offered on the input stream
    typedef struct packed {
        logic       last;
        logic [7:0] ch;
    } text_item_t;

    // one parse outcome as expected on the result stream
    typedef struct packed {
        logic                        ok;
        logic [ipap_pkg::ADDR_W-1:0] addr;
        logic [ipap_pkg::PORT_W-1:0] port;
    } parse_result_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata   = '0;    // text_char
    logic                             s_tlast   = 1'b0;  // last_char
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [ipap_pkg::OUT_DATA_W-1:0]  m_tdata;           // ipv4_address, port_number
    logic                             m_tuser;           // valid_res
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ipap_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ipap_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // stimulus and expectation stores
    text_item_t    pending_chars[$];
    logic [7:0]    text_buf[$];
    parse_result_t expected_results[$];

    int queued_chars   = 0;
    int accepted_chars = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    // idling control: odds of 1 in idle_odds to start a burst, 0 means none
    int idle_odds   = 6;
    bit hold_armed  = 1'b0;
    bit hold_done   = 1'b0;
    int gap_left    = 0;
    int stall_left  = 0;
    text_item_t    next_item;
    parse_result_t want;

    // predictor copy of the registers
    logic [ipap_pkg::PORT_W-1:0] dflt_port = ipap_pkg::DEFAULT_PORT_RST;
    logic [ipap_pkg::ADDR_W-1:0] loop_addr = ipap_pkg::LOOPBACK_RST;

    // predictor copy of the parse state
    ipap_pkg::phase_t prs_phase;
    logic [6:0]  prs_len;
    logic        prs_gap;       // whitespace seen after the text began
    logic [2:0]  oct_idx;
    logic [2:0]  oct_digits;
    logic [9:0]  oct_val;
    logic [31:0] addr_acc;
    logic [2:0]  port_digits;
    logic [16:0] port_acc;
    logic [3:0]  name_pos;
    logic        name_ok;       // still could be the loopback name
    logic        quad_ok;       // still could be a dotted quad
    logic        text_bad;

    ipv4_address_port_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void clear_parse();
        prs_phase   = ipap_pkg::PH_LEAD;
        prs_len     = '0;
        prs_gap     = 1'b0;
        oct_idx     = '0;
        oct_digits  = '0;
        oct_val     = '0;
        addr_acc    = '0;
        port_digits = '0;
        port_acc    = '0;
        name_pos    = '0;
        name_ok     = 1'b1;
        quad_ok     = 1'b1;
        text_bad    = 1'b0;
    endfunction

    // space and the control codes tab through carriage return
    function automatic bit is_blank(input logic [7:0] c);
        return c == ipap_pkg::CH_SPACE || (c >= ipap_pkg::CH_TAB && c <= ipap_pkg::CH_CR);
    endfunction

    // fold the final octet in; a full quad leaves the index at four
    function automatic void close_quad();
        if (quad_ok && oct_idx == 3'd3 && oct_digits != 0 && oct_val <= 10'd255) begin
            addr_acc = {addr_acc[23:0], oct_val[7:0]};
            oct_idx  = 3'd4;
        end else begin
            quad_ok = 1'b0;
        end
    endfunction

    function automatic void host_char(input logic [7:0] c);
        logic [7:0] low;
        low = (c >= ipap_pkg::CH_UPA && c <= ipap_pkg::CH_UPZ) ? c + ipap_pkg::CASE_OFS : c;
        if (name_ok) begin
            if (name_pos < ipap_pkg::NAME_LEN && low == HOST_NAME[name_pos]) begin
                name_pos++;
            end else begin
                name_ok = 1'b0;
            end
        end
        if (!quad_ok) return;
        if (c == ipap_pkg::CH_DOT) begin
            if (oct_digits == 0 || oct_val > 10'd255 || oct_idx >= 3'd3) begin
                quad_ok = 1'b0;
            end else begin
                addr_acc   = {addr_acc[23:0], oct_val[7:0]};
                oct_idx++;
                oct_digits = '0;
                oct_val    = '0;
            end
        end else if (c >= ipap_pkg::CH_ZERO && c <= ipap_pkg::CH_NINE) begin
            if (oct_digits >= 3'd3) begin
                quad_ok = 1'b0;
            end else begin
                oct_val = 10'(oct_val * 10'd10 + 10'(c - ipap_pkg::CH_ZERO));
                oct_digits++;
            end
        end else begin
            quad_ok = 1'b0;
        end
    endfunction

    function automatic void take_char(input logic [7:0] c);
        if (text_bad) return;
        if (is_blank(c)) begin
            if (prs_phase != ipap_pkg::PH_LEAD) prs_gap = 1'b1;
            return;
        end
        // ordinary character after inner whitespace, or text too long
        if (prs_gap || prs_len >= ipap_pkg::MAX_TEXT_LENGTH_DEF) begin
            text_bad = 1'b1;
            return;
        end
        prs_len++;
        if (prs_phase == ipap_pkg::PH_LEAD) prs_phase = ipap_pkg::PH_HOST;
        if (prs_phase == ipap_pkg::PH_HOST) begin
            if (c == ipap_pkg::CH_COLON) begin
                close_quad();
                prs_phase = ipap_pkg::PH_PORT;
            end else begin
                host_char(c);
            end
        end else if (c >= ipap_pkg::CH_ZERO && c <= ipap_pkg::CH_NINE
                     && port_digits < 3'd5) begin
            port_acc = 17'(port_acc * 17'd10 + 17'(c - ipap_pkg::CH_ZERO));
            port_digits++;
        end else begin
            text_bad = 1'b1;
        end
    endfunction

    // one character in; on the last one an outcome is queued and the state clears
    function automatic void parse_char(input logic [7:0] c, input logic last);
        parse_result_t r;
        logic [16:0]   port_val;
        take_char(c);
        if (!last) return;
        r        = '0;
        port_val = '0;
        r.ok     = !text_bad && prs_len != 0 && prs_phase != ipap_pkg::PH_LEAD;
        if (r.ok) begin
            if (prs_phase == ipap_pkg::PH_HOST) begin
                close_quad();
                port_val = {1'b0, dflt_port};
            end else begin
                port_val = (port_digits != 0) ? port_acc : '0;
            end
            if (port_val < 1 || port_val > 17'd65535) r.ok = 1'b0;
        end
        if (r.ok) begin
            if (name_ok && name_pos == ipap_pkg::NAME_LEN) begin
                r.addr = loop_addr;
            end else if (quad_ok && oct_idx == 3'd4) begin
                r.addr = addr_acc;
            end else begin
                r.ok = 1'b0;
            end
        end
        if (r.ok) begin
            r.port = port_val[15:0];
        end else begin
            r.addr = '0;
            r.port = '0;
        end
        expected_results.push_back(r);
        clear_parse();
    endfunction

    initial clear_parse();

    // ---------------------------------------------------------------
    // input driver: one item per handshake, random gap bursts
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                gap_left = $urandom_range(0, 15);
                s_tvalid <= 1'b0;
            end else if (pending_chars.size() != 0) begin
                next_item = pending_chars.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.ch;
                s_tlast  <= next_item.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result receiver: random stall bursts plus one long hold-off
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            stall_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // monitor: check results, track register writes, predict on input
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result item with none expected, valid %0b data %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.ok) begin
                        error_count++;
                        $display("%0t: valid flag expected %0b, got %0b",
                                 $time, want.ok, m_tuser);
                    end
                    if (m_tdata[ipap_pkg::ADDR_W-1:0] !== want.addr) begin
                        error_count++;
                        $display("%0t: address expected %h, got %h",
                                 $time, want.addr, m_tdata[ipap_pkg::ADDR_W-1:0]);
                    end
                    if (m_tdata[ipap_pkg::OUT_DATA_W-1:ipap_pkg::ADDR_W] !== want.port) begin
                        error_count++;
                        $display("%0t: port expected %0d, got %0d",
                                 $time, want.port,
                                 m_tdata[ipap_pkg::OUT_DATA_W-1:ipap_pkg::ADDR_W]);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ipap_pkg::CFG_DEFAULT_PORT) begin
                    dflt_port = cfg_data[ipap_pkg::PORT_W-1:0];
                end else if (cfg_index == ipap_pkg::CFG_LOOPBACK) begin
                    loop_addr = cfg_data[ipap_pkg::ADDR_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                accepted_chars++;
                parse_char(s_tdata, s_tlast);
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ipv4_address_port_parser verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic write_reg(input logic [ipap_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ipap_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // wait until every item is taken and every result is back, then let it settle
    task automatic wait_quiet();
        while (accepted_chars != queued_chars || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_item(input logic [7:0] c, input logic last);
        text_item_t it;
        it.ch   = c;
        it.last = last;
        pending_chars.push_back(it);
        queued_chars++;
    endtask

    function automatic logic [7:0] blank_char();
        if ($urandom_range(0, 1)) return ipap_pkg::CH_SPACE;
        return 8'($urandom_range(ipap_pkg::CH_TAB, ipap_pkg::CH_CR));
    endfunction

    // mostly digits, with separators, whitespace and arbitrary codes mixed in
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return ipap_pkg::CH_DOT;
            1:       return ipap_pkg::CH_COLON;
            2:       return blank_char();
            3, 4:    return 8'($urandom_range(0, 255));
            default: return ipap_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic add_blank(input int n);
        repeat (n) text_buf.push_back(blank_char());
    endtask

    // decimal number, sometimes zero-padded up to the field's digit limit
    task automatic add_number(input int v, input int max_w);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(0, max_w - s.len())) text_buf.push_back(ipap_pkg::CH_ZERO);
        add_str(s);
    endtask

    // flush the text buffer as one text, last mark on its final character
    task automatic send_text();
        if (text_buf.size() == 0) text_buf.push_back(blank_char());
        for (int i = 0; i < text_buf.size(); i++) push_item(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic add_quad();
        int v;
        for (int i = 0; i < 4; i++) begin
            if (i != 0) text_buf.push_back(ipap_pkg::CH_DOT);
            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = 255;
                default: v = $urandom_range(0, 255);
            endcase
            add_number(v, 3);
        end
    endtask

    task automatic add_host_name();
        logic [7:0] c;
        for (int i = 0; i < ipap_pkg::NAME_LEN; i++) begin
            c = HOST_NAME[i];
            if ($urandom_range(0, 1)) c = c - ipap_pkg::CASE_OFS;
            text_buf.push_back(c);
        end
    endtask

    task automatic add_random_text();
        int kind;
        int pos;
        int pv;
        kind = $urandom_range(0, 99);
        if (kind < 3) begin
            add_blank($urandom_range(0, 4));
        end else if (kind < 8) begin
            // around the length limit
            repeat ($urandom_range(58, 72)) text_buf.push_back(pick_char());
        end else begin
            if ($urandom_range(0, 3) == 0) add_blank($urandom_range(1, 3));
            if (kind < 30) begin
                add_host_name();
            end else begin
                add_quad();
            end
            if ($urandom_range(0, 2) != 0) begin
                text_buf.push_back(ipap_pkg::CH_COLON);
                case ($urandom_range(0, 7))
                    0:       pv = 1;
                    1:       pv = 65535;
                    2:       pv = $urandom_range(1, 99);
                    default: pv = $urandom_range(1, 65535);
                endcase
                add_number(pv, 5);
            end
            if ($urandom_range(0, 3) == 0) add_blank($urandom_range(1, 3));
            // broken variant: one character replaced, inserted or dropped
            if (kind >= 75) begin
                pos = $urandom_range(0, text_buf.size() - 1);
                case ($urandom_range(0, 2))
                    0:       text_buf[pos] = pick_char();
                    1:       text_buf.insert(pos, pick_char());
                    default: text_buf.delete(pos);
                endcase
            end
        end
        send_text();
    endtask

    // arbitrary codes with arbitrary last marks, closed by a last mark
    task automatic add_noise();
        repeat ($urandom_range(1, 24))
            push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        push_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic run_random(input int n);
        int target;
        target = queued_chars + n;
        while (queued_chars < target) begin
            if ($urandom_range(0, 19) == 0) begin
                add_noise();
            end else begin
                add_random_text();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed texts with reset register values
        add_str("255.255.255.255:65535"); send_text();
        add_str("0.0.0.0:1");             send_text();
        add_blank(2); add_str("LocalHost"); add_blank(2); send_text();
        add_str("LOCALHOST:80");          send_text();
        add_str("localhos");              send_text();
        add_str("localhostx");            send_text();
        add_blank(3);                     send_text();
        add_str("010.0.0.1:00080");       send_text();
        add_str("256.1.1.1");             send_text();
        add_str("1..2.3");                send_text();
        add_str("1.2.3");                 send_text();
        add_str("1.2.3.4:");              send_text();
        add_str(":80");                   send_text();
        add_str("1.2.3.4:0");             send_text();
        add_str("1.2.3.4:65536");         send_text();
        add_str("1.2.3.4:1:2");           send_text();
        add_str("1.2"); add_blank(1); add_str(".3.4"); send_text();
        add_str("1234.1.1.1");            send_text();
        // codes outside printable ASCII are ordinary characters
        text_buf.push_back(8'h00); add_str("1.2.3.4"); send_text();
        add_str("1.2.3.4"); text_buf.push_back(8'h80); send_text();
        add_str("9.9.9.9:"); text_buf.push_back(8'hFF); send_text();
        // exactly at and just over the length limit
        repeat (ipap_pkg::MAX_TEXT_LENGTH_DEF) text_buf.push_back(ipap_pkg::CH_ZERO);
        send_text();
        add_str("1.2.3.4:");
        repeat (ipap_pkg::MAX_TEXT_LENGTH_DEF - 7) text_buf.push_back(ipap_pkg::CH_ZERO);
        send_text();
        run_random(50);
        wait_quiet();

        // lowest register values
        write_reg(ipap_pkg::CFG_DEFAULT_PORT, 32'd1);
        write_reg(ipap_pkg::CFG_LOOPBACK, 32'h0000_0000);
        idle_odds = 4;
        run_random(250);
        wait_quiet();

        // highest register values; receiver holds off so the input backs up
        write_reg(ipap_pkg::CFG_DEFAULT_PORT, 32'd65535);
        write_reg(ipap_pkg::CFG_LOOPBACK, 32'hFFFF_FFFF);
        idle_odds  = 8;
        hold_armed = 1'b1;
        run_random(250);
        wait_quiet();

        // zero default port makes every text without a colon invalid
        write_reg(ipap_pkg::CFG_DEFAULT_PORT, 32'd0);
        write_reg(ipap_pkg::CFG_LOOPBACK, $urandom);
        idle_odds = 3;
        run_random(200);
        wait_quiet();

        write_reg(ipap_pkg::CFG_LOOPBACK, $urandom);
        write_reg(ipap_pkg::CFG_DEFAULT_PORT, $urandom_range(1, 65535));
        idle_odds = 5;
        run_random(200);
        wait_quiet();

        // back to power-up values, full rate on both sides
        write_reg(ipap_pkg::CFG_DEFAULT_PORT, 32'd7777);
        write_reg(ipap_pkg::CFG_LOOPBACK, 32'h7F00_0001);
        idle_odds = 0;
        run_random(100);
        wait_quiet();

        if (error_count == 0) begin
            $display("ipv4_address_port_parser verification clean");
        end else begin
            $display("ipv4_address_port_parser verification failed");
        end
        $finish;
    end

endmodule
